// ===== sv/qbd_pkg.sv =====
// Shared types, constants and a helper function for the QOI byte stream decoder.
package qbd_pkg;

  // Color table, pixel counter, color, run and configuration sizing.
  localparam int TABLE_ENTRIES   = 64;
  localparam int TABLE_AW        = $clog2(TABLE_ENTRIES);
  localparam int COUNT_WIDTH     = 32;
  localparam int COLOR_WIDTH     = 32;
  localparam int RUN_WIDTH       = 6;
  localparam int RUN_MAX         = (1 << RUN_WIDTH) - 1;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA_EN     = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMAGE_PIXELS = CFG_INDEX_WIDTH'(1);

  // Op byte codes and two-bit tags.
  localparam logic [7:0] OP_RGB    = 8'hFE;
  localparam logic [7:0] OP_RGBA   = 8'hFF;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;

  // Biases that turn the unsigned delta fields into wrapped signed offsets, and the opaque alpha.
  localparam logic [7:0] DIFF_BIAS  = 8'hFE;
  localparam logic [7:0] LUMA_BIAS  = 8'hE0;
  localparam logic [7:0] CHROMA_BIAS = 8'hF8;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Last color after reset or at image start: black, fully opaque.
  localparam logic [COLOR_WIDTH-1:0] LAST_RESET = 32'h0000_00FF;

  // Position within a multi-byte op.
  typedef enum logic [3:0] {
    PH_WAIT   = 4'd0,
    PH_RGB_R  = 4'd1,
    PH_RGB_G  = 4'd2,
    PH_RGB_B  = 4'd3,
    PH_RGBA_R = 4'd4,
    PH_RGBA_G = 4'd5,
    PH_RGBA_B = 4'd6,
    PH_RGBA_A = 4'd7,
    PH_LUMA   = 4'd8
  } phase_e;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    phase_e                  phase;
    logic [7:0]              luma;
    logic [COLOR_WIDTH-1:0]  partial;
    logic [COLOR_WIDTH-1:0]  last;
    logic [COUNT_WIDTH-1:0]  pixels;
  } dec_state_t;

  // What one byte does: pixels to emit, their color, and the state after it.
  typedef struct packed {
    logic                    emit;
    logic [RUN_WIDTH-1:0]    count;
    logic [COLOR_WIDTH-1:0]  color;
    dec_state_t              next;
  } step_t;

  // Color table slot: (r*3 + g*5 + b*7 + a*11) mod table size.
  function automatic logic [TABLE_AW-1:0] hash_slot(input logic [COLOR_WIDTH-1:0] color);
    logic [7:0] sum;
    sum = color[31:24] * 8'd3 + color[23:16] * 8'd5 + color[15:8] * 8'd7
        + color[7:0] * 8'd11;
    return sum[TABLE_AW-1:0];
  endfunction

endpackage

// ===== sv/qoi_byte_stream_decoder.sv =====
// Top level of the QOI byte stream decoder: input stage, state, table and pixel register.
//
// Takes one QOI chunk byte per cycle when the input does not stall and gives decoded pixels
// through a pixel output register loaded from the decode stage once it is free. A byte that
// makes no pixel or one pixel waits at most for that register to be free, so such bytes
// flow at one per cycle when the output does not stall. A run byte of n pixels holds the
// decode stage until all n have gone into the output register, one pixel per cycle when
// the output does not stall, and the input stalls meanwhile; output stalls hold the
// decode stage as well. The 64-entry color table sits in a RAM with a registered read that
// is started as the byte is taken; a valid bit per entry makes the table read as zero
// after start_image, so there is no clearing pass. Configuration writes are taken at any
// time (ready is always high) but are meant to be made only while the block is idle.
module qoi_byte_stream_decoder (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Byte input
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [7:0]                             byte_value_i,
  input  logic                                   start_image_i,
  // Pixel output
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [7:0]                             red_o,
  output logic [7:0]                             green_o,
  output logic [7:0]                             blue_o,
  output logic [7:0]                             alpha_o,
  output logic                                   run_last_o,
  output logic                                   image_done_o,
  // Configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [qbd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index_i,
  input  logic [qbd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data_i
);

  logic                                  alpha_en_q;
  logic [qbd_pkg::CFG_DATA_WIDTH-1:0]    image_pixels_q;
  logic                                  s1_valid_q;
  logic [7:0]                            s1_byte_q;
  logic                                  s1_start_q;
  logic                                  fwd_q;
  logic [qbd_pkg::COLOR_WIDTH-1:0]       fwd_data_q;
  qbd_pkg::dec_state_t                   state_q;
  logic [qbd_pkg::TABLE_ENTRIES-1:0]     valid_q, valid_d;
  logic                                  busy_q;
  logic [qbd_pkg::RUN_WIDTH-1:0]         run_left_q;
  logic                                  out_valid_q;
  logic [qbd_pkg::COLOR_WIDTH-1:0]       out_color_q;
  logic                                  out_run_last_q;
  logic                                  out_image_done_q;

  logic                                  accept;
  logic                                  out_free;
  logic                                  go;
  logic                                  s1_done;
  logic                                  out_load;
  logic [qbd_pkg::COUNT_WIDTH-1:0]       limit;
  logic [qbd_pkg::COUNT_WIDTH-1:0]       pixels_next;
  logic [qbd_pkg::COLOR_WIDTH-1:0]       pixel_color;
  logic                                  pixel_last;
  logic [qbd_pkg::COLOR_WIDTH-1:0]       ram_rdata;
  logic [qbd_pkg::COLOR_WIDTH-1:0]       table_color;
  logic                                  table_we;
  logic [qbd_pkg::TABLE_AW-1:0]          table_waddr;
  logic [qbd_pkg::TABLE_AW-1:0]          in_slot;
  logic [qbd_pkg::TABLE_AW-1:0]          s1_slot;
  qbd_pkg::step_t                        step;

  assign limit    = image_pixels_q[qbd_pkg::COUNT_WIDTH-1:0];
  assign in_slot  = byte_value_i[qbd_pkg::TABLE_AW-1:0];
  assign s1_slot  = s1_byte_q[qbd_pkg::TABLE_AW-1:0];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_en_q     <= 1'b1;
      image_pixels_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        qbd_pkg::REG_ALPHA_EN:     alpha_en_q     <= cfg_data_i[0];
        qbd_pkg::REG_IMAGE_PIXELS: image_pixels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake between the input stage, the decode step and the output register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign go         = s1_valid_q && (busy_q || !step.emit ? (busy_q ? out_free : 1'b1) : out_free);
  assign s1_done    = go && (busy_q ? (run_left_q == qbd_pkg::RUN_WIDTH'(1))
                                    : (step.count < qbd_pkg::RUN_WIDTH'(2)));
  assign out_load   = go && (busy_q || step.emit);
  assign in_stall_o = s1_valid_q && !s1_done;
  assign accept     = in_valid_i && !in_stall_o;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  // A table write in the same cycle as the read is passed on to the read side.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q  <= byte_value_i;
      s1_start_q <= start_image_i;
      fwd_q      <= table_we && (table_waddr == in_slot);
      fwd_data_q <= step.color;
    end
  end

  // Color table storage.
  qbd_ram #(
    .WIDTH (qbd_pkg::COLOR_WIDTH),
    .DEPTH (qbd_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (table_we),
    .waddr_i (table_waddr),
    .wdata_i (step.color),
    .re_i    (accept),
    .raddr_i (in_slot),
    .rdata_o (ram_rdata)
  );

  // Entries not written since the image began read as zero.
  assign table_color = (!s1_start_q && valid_q[s1_slot]) ?
                       (fwd_q ? fwd_data_q : ram_rdata) : '0;

  // Decode of the byte in the input stage.
  qbd_op_eval u_op_eval (
    .byte_value_i  (s1_byte_q),
    .start_image_i (s1_start_q),
    .state_i       (state_q),
    .table_color_i (table_color),
    .limit_i       (limit),
    .step_o        (step)
  );

  assign table_we    = go && !busy_q && step.emit;
  assign table_waddr = qbd_pkg::hash_slot(step.color);

  // Valid bits: cleared at image start, set on each table write.
  always_comb begin
    valid_d = valid_q;
    if (go && !busy_q && s1_start_q) begin
      valid_d = '0;
    end
    if (table_we) begin
      valid_d[table_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Decoder state and run progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= qbd_pkg::PH_WAIT;
      state_q.luma    <= '0;
      state_q.partial <= '0;
      state_q.last    <= qbd_pkg::LAST_RESET;
      state_q.pixels  <= '0;
      busy_q          <= 1'b0;
      run_left_q      <= '0;
    end else if (go) begin
      if (busy_q) begin
        state_q.pixels <= pixels_next;
        run_left_q     <= run_left_q - qbd_pkg::RUN_WIDTH'(1);
        if (run_left_q == qbd_pkg::RUN_WIDTH'(1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        state_q <= step.next;
        if (step.count > qbd_pkg::RUN_WIDTH'(1)) begin
          busy_q     <= 1'b1;
          run_left_q <= step.count - qbd_pkg::RUN_WIDTH'(1);
        end
      end
    end
  end

  // Pixel sent this cycle.
  assign pixel_color = busy_q ? state_q.last : step.color;
  assign pixels_next = busy_q ? (state_q.pixels + qbd_pkg::COUNT_WIDTH'(1)) : step.next.pixels;
  assign pixel_last  = busy_q ? (run_left_q == qbd_pkg::RUN_WIDTH'(1))
                              : (step.count == qbd_pkg::RUN_WIDTH'(1));

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_color_q      <= {pixel_color[31:8],
                           alpha_en_q ? pixel_color[7:0] : qbd_pkg::ALPHA_OPAQUE};
      out_run_last_q   <= pixel_last;
      out_image_done_q <= (pixels_next == limit);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = out_color_q[31:24];
  assign green_o      = out_color_q[23:16];
  assign blue_o       = out_color_q[15:8];
  assign alpha_o      = out_color_q[7:0];
  assign run_last_o   = out_run_last_q;
  assign image_done_o = out_image_done_q;

endmodule

// ===== sv/qbd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module qbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the word holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/qbd_op_eval.sv =====
// Op decoder: works out what one chunk byte does to the decoder state.
module qbd_op_eval (
  input  logic [7:0]                           byte_value_i,
  input  logic                                 start_image_i,
  input  qbd_pkg::dec_state_t                  state_i,
  input  logic [qbd_pkg::COLOR_WIDTH-1:0]      table_color_i,
  input  logic [qbd_pkg::COUNT_WIDTH-1:0]      limit_i,
  output qbd_pkg::step_t                       step_o
);

  qbd_pkg::dec_state_t                  cur;
  qbd_pkg::dec_state_t                  nxt;
  logic [7:0]                           r0, g0, b0, a0, dg;
  logic [qbd_pkg::COUNT_WIDTH-1:0]      remaining;
  logic [qbd_pkg::RUN_WIDTH-1:0]        remaining_clip;
  logic [qbd_pkg::RUN_WIDTH-1:0]        want;
  logic [qbd_pkg::RUN_WIDTH-1:0]        count;
  logic [qbd_pkg::COLOR_WIDTH-1:0]      color;
  logic                                 emit;

  // A new image wipes the state before this byte is looked at.
  always_comb begin
    cur = state_i;
    if (start_image_i) begin
      cur.phase   = qbd_pkg::PH_WAIT;
      cur.luma    = '0;
      cur.partial = '0;
      cur.last    = qbd_pkg::LAST_RESET;
      cur.pixels  = '0;
    end
  end

  assign r0 = cur.last[31:24];
  assign g0 = cur.last[23:16];
  assign b0 = cur.last[15:8];
  assign a0 = cur.last[7:0];
  assign dg = cur.luma;

  // Next phase and the partially assembled color.
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      qbd_pkg::PH_WAIT: begin
        if (byte_value_i == qbd_pkg::OP_RGB) begin
          nxt.partial = {24'd0, a0};
          nxt.phase   = qbd_pkg::PH_RGB_R;
        end else if (byte_value_i == qbd_pkg::OP_RGBA) begin
          nxt.partial = '0;
          nxt.phase   = qbd_pkg::PH_RGBA_R;
        end else if (byte_value_i[7:6] == qbd_pkg::TAG_LUMA) begin
          nxt.luma  = {2'b00, byte_value_i[5:0]} + qbd_pkg::LUMA_BIAS;
          nxt.phase = qbd_pkg::PH_LUMA;
        end
      end
      qbd_pkg::PH_RGB_R, qbd_pkg::PH_RGBA_R: begin
        nxt.partial[31:24] = byte_value_i;
        nxt.phase = (cur.phase == qbd_pkg::PH_RGB_R) ? qbd_pkg::PH_RGB_G : qbd_pkg::PH_RGBA_G;
      end
      qbd_pkg::PH_RGB_G, qbd_pkg::PH_RGBA_G: begin
        nxt.partial[23:16] = byte_value_i;
        nxt.phase = (cur.phase == qbd_pkg::PH_RGB_G) ? qbd_pkg::PH_RGB_B : qbd_pkg::PH_RGBA_B;
      end
      qbd_pkg::PH_RGB_B: begin
        nxt.partial[15:8] = byte_value_i;
        nxt.phase = qbd_pkg::PH_WAIT;
      end
      qbd_pkg::PH_RGBA_B: begin
        nxt.partial[15:8] = byte_value_i;
        nxt.phase = qbd_pkg::PH_RGBA_A;
      end
      qbd_pkg::PH_RGBA_A: begin
        nxt.partial[7:0] = byte_value_i;
        nxt.phase = qbd_pkg::PH_WAIT;
      end
      qbd_pkg::PH_LUMA: begin
        nxt.phase = qbd_pkg::PH_WAIT;
      end
      default: begin
        nxt.phase = qbd_pkg::PH_WAIT;
      end
    endcase
  end

  // Pixel color and how many copies the byte asks for.
  always_comb begin
    want  = '0;
    color = cur.last;
    unique case (cur.phase)
      qbd_pkg::PH_WAIT: begin
        if (byte_value_i != qbd_pkg::OP_RGB && byte_value_i != qbd_pkg::OP_RGBA) begin
          unique case (byte_value_i[7:6])
            qbd_pkg::TAG_INDEX: begin
              want  = qbd_pkg::RUN_WIDTH'(1);
              color = table_color_i;
            end
            qbd_pkg::TAG_DIFF: begin
              want  = qbd_pkg::RUN_WIDTH'(1);
              color = {r0 + {6'd0, byte_value_i[5:4]} + qbd_pkg::DIFF_BIAS,
                       g0 + {6'd0, byte_value_i[3:2]} + qbd_pkg::DIFF_BIAS,
                       b0 + {6'd0, byte_value_i[1:0]} + qbd_pkg::DIFF_BIAS,
                       a0};
            end
            qbd_pkg::TAG_LUMA: begin
              want = '0;
            end
            default: begin
              // Run of the last color; the two longest codes are the RGB ops.
              want  = byte_value_i[5:0] + qbd_pkg::RUN_WIDTH'(1);
              color = cur.last;
            end
          endcase
        end
      end
      qbd_pkg::PH_RGB_B: begin
        want  = qbd_pkg::RUN_WIDTH'(1);
        color = {cur.partial[31:16], byte_value_i, cur.partial[7:0]};
      end
      qbd_pkg::PH_RGBA_A: begin
        want  = qbd_pkg::RUN_WIDTH'(1);
        color = {cur.partial[31:8], byte_value_i};
      end
      qbd_pkg::PH_LUMA: begin
        want  = qbd_pkg::RUN_WIDTH'(1);
        color = {r0 + dg + {4'd0, byte_value_i[7:4]} + qbd_pkg::CHROMA_BIAS,
                 g0 + dg,
                 b0 + dg + {4'd0, byte_value_i[3:0]} + qbd_pkg::CHROMA_BIAS,
                 a0};
      end
      default: begin
        want = '0;
      end
    endcase
  end

  // Clip the pixel count at what is left of the image.
  assign remaining = (cur.pixels < limit_i) ? (limit_i - cur.pixels) : '0;
  assign remaining_clip = (remaining > qbd_pkg::COUNT_WIDTH'(qbd_pkg::RUN_MAX)) ?
                          qbd_pkg::RUN_WIDTH'(qbd_pkg::RUN_MAX) :
                          remaining[qbd_pkg::RUN_WIDTH-1:0];
  assign count = (want < remaining_clip) ? want : remaining_clip;
  assign emit  = (count != '0);

  // Result of the byte; the first emitted pixel is counted here.
  always_comb begin
    step_o.emit  = emit;
    step_o.count = count;
    step_o.color = color;
    step_o.next  = nxt;
    if (emit) begin
      step_o.next.last   = color;
      step_o.next.pixels = cur.pixels + qbd_pkg::COUNT_WIDTH'(1);
    end
  end

endmodule

// ===== sv/qbd_checker.sv =====
// Port-level checks for the QOI byte stream decoder, bound to the top level.
module qbd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [7:0]                          red_o,
  input logic [7:0]                          green_o,
  input logic [7:0]                          blue_o,
  input logic [7:0]                          alpha_o,
  input logic                                run_last_o,
  input logic                                image_done_o
);

  // The last pixel of an image always closes the byte's pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_done_o) |-> run_last_o)
    else $error("image_done without run_last");

  // Inside a run the next pixel follows at once with the same color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !run_last_o) |=>
      (out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o)
       && $stable(alpha_o)))
    else $error("run pixel missing or changed color");

  // A stall with an empty output register means a pixel is on its way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !out_valid_o) |=> out_valid_o)
    else $error("input stalled with nothing to send");

  // A stalled pixel word holds: red, run_last and image_done are checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(red_o) && $stable(run_last_o) && $stable(image_done_o)))
    else $error("stalled pixel word changed");

endmodule

bind qoi_byte_stream_decoder qbd_checker u_qbd_checker (.*);

// ===== dv/tb_qoi_byte_stream_decoder.sv =====
// Self-checking testbench for the QOI byte stream decoder: directed chunks, then random images.
module tb_qoi_byte_stream_decoder;

  localparam int RANDOM_BYTES  = 340;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DIR_CFG_ROW   = 2;
  localparam logic [1:0] TAG_RUN = 2'b11;
  localparam logic [qbd_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED =
    qbd_pkg::CFG_INDEX_WIDTH'(15);

  // One decoded pixel word as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_last;
    logic       image_done;
  } pixel_t;

  // One directed byte; a typed row carries the single pixel it must produce.
  typedef struct packed {
    logic       start;
    logic [7:0] code;
    logic       typed;
    pixel_t     want;
  } chunk_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] byte_value_i = 8'h00;
  logic start_image_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] red_o, green_o, blue_o, alpha_o;
  logic run_last_o, image_done_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [qbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [qbd_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i = '0;

  // Decoder state as the testbench tracks it.
  logic                                alpha_on;
  logic [qbd_pkg::CFG_DATA_WIDTH-1:0]  pixel_limit;
  qbd_pkg::phase_e                     dec_phase;
  logic [7:0]                          luma_dg;
  logic [qbd_pkg::COLOR_WIDTH-1:0]     partial_px;
  logic [qbd_pkg::COLOR_WIDTH-1:0]     last_px;
  logic [qbd_pkg::COLOR_WIDTH-1:0]     recent_colors [qbd_pkg::TABLE_ENTRIES];
  logic [qbd_pkg::COUNT_WIDTH-1:0]     pixels_out;

  pixel_t     pending_pixels [$];
  chunk_row_t chunk_rows [$];
  pixel_t     seen_px, want_px;
  int         errors = 0;
  int         stall_left = 0;
  int         cycles = 0;
  int         random_bytes = 0;
  logic       start_next = 1'b0;
  logic       calm = 1'b0;

  always #5 clk_i = ~clk_i;

  qoi_byte_stream_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_value_i (byte_value_i),
    .start_image_i(start_image_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .run_last_o   (run_last_o),
    .image_done_o (image_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Table slot of a color: weighted channel sum modulo the table size.
  function automatic int unsigned color_slot(input logic [qbd_pkg::COLOR_WIDTH-1:0] px);
    int unsigned sum;
    sum = 32'(px[31:24]) * 3 + 32'(px[23:16]) * 5 + 32'(px[15:8]) * 7 + 32'(px[7:0]) * 11;
    return sum % qbd_pkg::TABLE_ENTRIES;
  endfunction

  // Start of a new image: black opaque last color, empty table, no pixels out.
  function automatic void clear_image();
    dec_phase  = qbd_pkg::PH_WAIT;
    luma_dg    = 8'h00;
    partial_px = '0;
    last_px    = qbd_pkg::LAST_RESET;
    pixels_out = '0;
    for (int i = 0; i < qbd_pkg::TABLE_ENTRIES; i++) recent_colors[i] = '0;
  endfunction

  // Queue up to count copies of a color, clipped at the image size.
  function automatic void emit_color(input logic [qbd_pkg::COLOR_WIDTH-1:0] px,
                                     input int unsigned count);
    logic [qbd_pkg::COUNT_WIDTH-1:0] limit;
    longint unsigned                 remaining;
    int unsigned                     n;
    pixel_t                          p;
    limit = pixel_limit[qbd_pkg::COUNT_WIDTH-1:0];
    remaining = (pixels_out < limit) ? longint'(limit - pixels_out) : 0;
    n = (count < remaining) ? count : int'(remaining);
    if (n == 0) return;
    last_px = px;
    recent_colors[color_slot(px)] = px;
    for (int k = 0; k < n; k++) begin
      pixels_out   = pixels_out + 1'b1;
      p.red        = px[31:24];
      p.green      = px[23:16];
      p.blue       = px[15:8];
      p.alpha      = alpha_on ? px[7:0] : qbd_pkg::ALPHA_OPAQUE;
      p.run_last   = (k == n - 1);
      p.image_done = (pixels_out == limit);
      pending_pixels.push_back(p);
    end
  endfunction

  // Advance the tracked decoder by one accepted byte.
  function automatic void decode_byte(input logic start, input logic [7:0] b);
    logic [7:0] r0, g0, b0, a0;
    logic [7:0] nr, ng, nb;
    if (start) clear_image();
    {r0, g0, b0, a0} = last_px;
    case (dec_phase)
      qbd_pkg::PH_WAIT: begin
        if (b == qbd_pkg::OP_RGB) begin
          partial_px = {24'd0, a0};
          dec_phase  = qbd_pkg::PH_RGB_R;
        end else if (b == qbd_pkg::OP_RGBA) begin
          partial_px = '0;
          dec_phase  = qbd_pkg::PH_RGBA_R;
        end else begin
          case (b[7:6])
            qbd_pkg::TAG_INDEX: emit_color(recent_colors[b[5:0]], 1);
            qbd_pkg::TAG_DIFF: begin
              nr = r0 + {6'd0, b[5:4]} + qbd_pkg::DIFF_BIAS;
              ng = g0 + {6'd0, b[3:2]} + qbd_pkg::DIFF_BIAS;
              nb = b0 + {6'd0, b[1:0]} + qbd_pkg::DIFF_BIAS;
              emit_color({nr, ng, nb, a0}, 1);
            end
            qbd_pkg::TAG_LUMA: begin
              luma_dg   = {2'b00, b[5:0]} + qbd_pkg::LUMA_BIAS;
              dec_phase = qbd_pkg::PH_LUMA;
            end
            default: emit_color(last_px, 32'(b[5:0]) + 1);
          endcase
        end
      end
      qbd_pkg::PH_RGB_R, qbd_pkg::PH_RGBA_R: begin
        partial_px[31:24] = b;
        dec_phase = (dec_phase == qbd_pkg::PH_RGB_R) ? qbd_pkg::PH_RGB_G : qbd_pkg::PH_RGBA_G;
      end
      qbd_pkg::PH_RGB_G, qbd_pkg::PH_RGBA_G: begin
        partial_px[23:16] = b;
        dec_phase = (dec_phase == qbd_pkg::PH_RGB_G) ? qbd_pkg::PH_RGB_B : qbd_pkg::PH_RGBA_B;
      end
      qbd_pkg::PH_RGB_B: begin
        partial_px[15:8] = b;
        dec_phase = qbd_pkg::PH_WAIT;
        emit_color(partial_px, 1);
      end
      qbd_pkg::PH_RGBA_B: begin
        partial_px[15:8] = b;
        dec_phase = qbd_pkg::PH_RGBA_A;
      end
      qbd_pkg::PH_RGBA_A: begin
        partial_px[7:0] = b;
        dec_phase = qbd_pkg::PH_WAIT;
        emit_color(partial_px, 1);
      end
      qbd_pkg::PH_LUMA: begin
        dec_phase = qbd_pkg::PH_WAIT;
        nr = r0 + luma_dg + {4'd0, b[7:4]} + qbd_pkg::CHROMA_BIAS;
        ng = g0 + luma_dg;
        nb = b0 + luma_dg + {4'd0, b[3:0]} + qbd_pkg::CHROMA_BIAS;
        emit_color({nr, ng, nb, a0}, 1);
      end
      default: dec_phase = qbd_pkg::PH_WAIT;
    endcase
  endfunction

  // Directed row whose pixels come from the tracked decoder.
  function automatic chunk_row_t plain_row(input logic start, input logic [7:0] code);
    chunk_row_t row;
    row       = '0;
    row.start = start;
    row.code  = code;
    return row;
  endfunction

  // Directed row with the one pixel it produces written out by hand.
  function automatic chunk_row_t typed_row(input logic start, input logic [7:0] code,
                                           input logic [31:0] color, input logic last,
                                           input logic done);
    chunk_row_t row;
    row       = plain_row(start, code);
    row.typed = 1'b1;
    row.want  = {color, last, done};
    return row;
  endfunction

  // Present one byte after a random gap and hold it until it is taken.
  task automatic send_byte(input logic start, input logic [7:0] code, input logic typed,
                           input pixel_t want);
    int gap;
    int mark;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_image_i <= start;
    byte_value_i  <= code;
    do @(posedge clk_i); while (in_stall_o);
    mark = pending_pixels.size();
    decode_byte(start, code);
    if (typed) begin
      while (pending_pixels.size() > mark) void'(pending_pixels.pop_back());
      pending_pixels.push_back(want);
    end
  endtask

  // Random-stream byte; the first byte of a new image carries start_image.
  task automatic feed(input logic [7:0] code);
    send_byte(start_next, code, 1'b0, '0);
    start_next = 1'b0;
    random_bytes++;
  endtask

  // Stop sending, let every pending pixel drain, then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the tracked copy follows once the write is taken.
  task automatic write_reg(input logic [qbd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [qbd_pkg::CFG_DATA_WIDTH-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == qbd_pkg::REG_ALPHA_EN) alpha_on = value[0];
    else if (idx == qbd_pkg::REG_IMAGE_PIXELS) pixel_limit = value;
  endtask

  task automatic write_settings(input logic alpha,
                                input logic [qbd_pkg::CFG_DATA_WIDTH-1:0] limit,
                                input logic poke_unused);
    write_reg(qbd_pkg::REG_ALPHA_EN, {{(qbd_pkg::CFG_DATA_WIDTH-1){1'b0}}, alpha});
    write_reg(qbd_pkg::REG_IMAGE_PIXELS, limit);
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Pixel checker and output stall generator.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_px = {red_o, green_o, blue_o, alpha_o, run_last_o, image_done_o};
        if (pending_pixels.size() == 0) begin
          $display("%0t: pixel expected none, got %h", $time, seen_px);
          errors++;
        end else begin
          want_px = pending_pixels.pop_front();
          check_field("red", want_px.red, seen_px.red);
          check_field("green", want_px.green, seen_px.green);
          check_field("blue", want_px.blue, seen_px.blue);
          check_field("alpha", want_px.alpha, seen_px.alpha);
          check_field("run_last", 8'(want_px.run_last), 8'(seen_px.run_last));
          check_field("image_done", 8'(want_px.image_done), 8'(seen_px.image_done));
        end
        stall_left = calm ? 0 : $urandom_range(0, 8);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("qoi_byte_stream_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          span;
    int          phase_from;
    int          pick;
    logic        fresh;
    logic [31:0] new_limit;

    alpha_on    = 1'b1;
    pixel_limit = '0;
    clear_image();

    // Under the reset image size of zero nothing may come out.
    chunk_rows.push_back(plain_row(1'b1, {TAG_RUN, 6'd61}));
    chunk_rows.push_back(plain_row(1'b0, 8'h7F));
    // RGB with all channels at full scale keeps the opaque alpha.
    chunk_rows.push_back(plain_row(1'b1, qbd_pkg::OP_RGB));
    chunk_rows.push_back(plain_row(1'b0, 8'hFF));
    chunk_rows.push_back(plain_row(1'b0, 8'hFF));
    chunk_rows.push_back(typed_row(1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
    // RGBA always takes its alpha byte, here fully transparent.
    chunk_rows.push_back(plain_row(1'b0, qbd_pkg::OP_RGBA));
    chunk_rows.push_back(plain_row(1'b0, 8'h00));
    chunk_rows.push_back(plain_row(1'b0, 8'h80));
    chunk_rows.push_back(plain_row(1'b0, 8'hFF));
    chunk_rows.push_back(typed_row(1'b0, 8'h00, 32'h0080_FF00, 1'b1, 1'b0));
    // DIFF and LUMA at both ends of their deltas.
    chunk_rows.push_back(plain_row(1'b0, 8'h40));
    chunk_rows.push_back(plain_row(1'b0, 8'h7F));
    chunk_rows.push_back(plain_row(1'b0, 8'h80));
    chunk_rows.push_back(plain_row(1'b0, 8'h00));
    chunk_rows.push_back(plain_row(1'b0, 8'hBF));
    chunk_rows.push_back(plain_row(1'b0, 8'hFF));
    // INDEX of the first and last slot.
    chunk_rows.push_back(plain_row(1'b0, 8'h00));
    chunk_rows.push_back(plain_row(1'b0, 8'h3F));
    // Shortest run, then the longest one clipped at the image end.
    chunk_rows.push_back(plain_row(1'b0, {TAG_RUN, 6'd0}));
    chunk_rows.push_back(plain_row(1'b0, {TAG_RUN, 6'd61}));
    // Image complete: bytes are parsed but give nothing.
    chunk_rows.push_back(plain_row(1'b0, 8'h55));
    chunk_rows.push_back(plain_row(1'b0, qbd_pkg::OP_RGB));
    chunk_rows.push_back(plain_row(1'b0, 8'h12));
    // A new image aborts the unfinished RGB op.
    chunk_rows.push_back(typed_row(1'b1, 8'h7F, 32'h0101_01FF, 1'b1, 1'b0));
    chunk_rows.push_back(plain_row(1'b0, {TAG_RUN, 6'd1}));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (chunk_rows[i]) begin
      if (i == DIR_CFG_ROW) begin
        wait_drained();
        write_settings(1'b1, 32'd30, 1'b0);
      end
      send_byte(chunk_rows[i].start, chunk_rows[i].code, chunk_rows[i].typed,
                chunk_rows[i].want);
    end

    // Random phases, each under its own settings; most begin a new image.
    for (int ph = 0; random_bytes < RANDOM_BYTES; ph++) begin
      kind  = (ph < 4) ? ph : $urandom_range(0, 9);
      fresh = (kind != 3) && ($urandom_range(0, 4) != 0);
      case (kind)
        0: new_limit = '0;
        1: new_limit = '1;
        2: new_limit = $urandom;
        3: new_limit = 32'(pixels_out / 2);   // lowered to half of what is already out
        default: new_limit = $urandom_range(1, 150);
      endcase
      wait_drained();
      write_settings((ph == 0) ? 1'b0 : 1'($urandom_range(0, 1)), new_limit, ph == 1);
      calm       = ($urandom_range(0, 3) == 0);
      span       = $urandom_range(20, 60);
      start_next = fresh;
      phase_from = random_bytes;
      while (random_bytes - phase_from < span) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          feed(qbd_pkg::OP_RGB);
          repeat (3) feed(8'($urandom_range(0, 255)));
        end else if (pick < 24) begin
          feed(qbd_pkg::OP_RGBA);
          repeat (4) feed(8'($urandom_range(0, 255)));
        end else if (pick < 42) begin
          feed({qbd_pkg::TAG_INDEX, 6'($urandom_range(0, 63))});
        end else if (pick < 60) begin
          feed({qbd_pkg::TAG_DIFF, 6'($urandom_range(0, 63))});
        end else if (pick < 75) begin
          feed({qbd_pkg::TAG_LUMA, 6'($urandom_range(0, 63))});
          feed(8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
          // Mostly short runs, sometimes up to the longest.
          if ($urandom_range(0, 4) == 0) feed({TAG_RUN, 6'($urandom_range(0, 61))});
          else feed({TAG_RUN, 6'($urandom_range(0, 7))});
        end else if (pick < 97) begin
          feed(8'($urandom_range(0, 255)));
        end else begin
          // A multi-byte op that the start of a new image may cut short.
          case ($urandom_range(0, 2))
            0: feed(qbd_pkg::OP_RGB);
            1: feed(qbd_pkg::OP_RGBA);
            default: feed({qbd_pkg::TAG_LUMA, 6'($urandom_range(0, 63))});
          endcase
          if ($urandom_range(0, 1) == 1) feed(8'($urandom_range(0, 255)));
          start_next = 1'b1;
        end
      end
    end

    calm = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("qoi_byte_stream_decoder: match");
    end else begin
      $display("qoi_byte_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== qoi_byte_stream_decoder.f =====
sv/qbd_pkg.sv
sv/qbd_ram.sv
sv/qbd_op_eval.sv
sv/qoi_byte_stream_decoder.sv
sv/qbd_checker.sv
dv/tb_qoi_byte_stream_decoder.sv
